### src/rrts_pkg.sv
// package for the round robin thread slot scheduler
// holds slot count, codes, transaction payload types and small helper functions
// no dependencies
package rrts_pkg;

   localparam int SLOT_COUNT = 8;
   localparam int SLOT_IDX_W = $clog2(SLOT_COUNT);
   localparam int SLOT_SUM_W = SLOT_IDX_W + 1;
   localparam int SLOT_CNT_W = $clog2(SLOT_COUNT + 1);

   typedef enum logic [1:0] {
      FUNC_INIT   = 2'd0,
      FUNC_CREATE = 2'd1,
      FUNC_YIELD  = 2'd2,
      FUNC_FINISH = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_NO_FREE   = 3'd1,
      STATUS_NONE_RDY  = 3'd2,
      STATUS_NOT_READY = 3'd3,
      STATUS_ALL_DONE  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      SLOT_INVALID = 2'd0,
      SLOT_READY   = 2'd1,
      SLOT_DONE    = 2'd2
   } slot_state_type;

   typedef logic [SLOT_IDX_W-1:0] slot_idx_type;
   typedef logic [SLOT_CNT_W-1:0] slot_cnt_type;

   typedef struct packed {
      logic [1:0]         func;
      logic [31:0]        entry_addr;
      logic signed [31:0] arg_a;
      logic signed [31:0] arg_b;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [2:0]         slot;
      logic [2:0]         others_ready;
      logic [31:0]        run_entry;
      logic signed [31:0] run_arg_a;
      logic signed [31:0] run_arg_b;
   } rsp_type;

   function automatic logic [2:0] slot_field(input slot_idx_type idx);
      logic [SLOT_IDX_W+2:0] ext;
      ext = {3'b000, idx};
      return ext[2:0];
   endfunction

   function automatic logic [2:0] sat_count(input slot_cnt_type cnt);
      logic [SLOT_CNT_W+2:0] ext;
      ext = {3'b000, cnt};
      if (ext > (SLOT_CNT_W + 3)'(7)) begin
         return 3'd7;
      end
      return ext[2:0];
   endfunction

endpackage

### src/round_robin_thread_slot_scheduler_unit.sv
// round robin thread slot scheduler, top level
// slot states and current slot in flops, entry and arguments in a one-port sync memory
// depends on rrts_pkg
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_ready  | req_data  (func, entry, args)
//   rsp     | out       | rsp_valid/rsp_ready  | rsp_data  (status, slot, count, run fields)
//
// each transaction has an accept step and a read step: the accept step decides and
// updates the slot table and issues the memory access, the read step loads the result
// register from the registered memory read. a stalled result holds the block in the
// read step, req_ready is low until it drains. reset restores the slot table and
// current slot, the memory is not cleared.
module round_robin_thread_slot_scheduler_unit
   import rrts_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   typedef struct packed {
      logic [31:0] entry;
      logic [31:0] arg_a;
      logic [31:0] arg_b;
   } slot_data_type;

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } fsm_type;

   fsm_type        fsm_ff;
   logic           rsp_valid_ff;
   rsp_type        rsp_ff;

   slot_state_type slot_state_ff [SLOT_COUNT];
   slot_idx_type   cur_ff;

   slot_data_type  slot_mem [SLOT_COUNT];
   slot_data_type  mem_rd_ff;

   logic [2:0]     pend_status_ff;
   logic [2:0]     pend_slot_ff;
   logic [2:0]     pend_others_ff;
   slot_data_type  pend_run_ff;
   logic           pend_use_mem_ff;

   logic [2:0]     pend_status_in;
   logic [2:0]     pend_slot_in;
   logic [2:0]     pend_others_in;
   slot_data_type  pend_run_in;
   logic           pend_use_mem_in;
   slot_idx_type   cur_in;

   logic           accept;
   logic           rsp_free;
   logic           do_init;
   logic           do_claim;
   logic           do_done;
   logic           mem_we;
   logic           mem_re;
   slot_idx_type   mem_addr;
   slot_data_type  mem_wdata;

   logic [SLOT_COUNT-1:0] ready_vec;
   logic [SLOT_COUNT-1:0] search_vec;
   logic                  next_found;
   slot_idx_type          next_idx;
   slot_cnt_type          ready_cnt;
   logic                  free_found;
   slot_idx_type          free_idx;

   assign accept    = req_valid && (fsm_ff == ST_IDLE);
   assign req_ready = (fsm_ff == ST_IDLE);
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign mem_wdata = '{entry: req_data.entry_addr, arg_a: req_data.arg_a,
                        arg_b: req_data.arg_b};

   // slot searches over the ready and invalid states
   always_comb begin
      logic [SLOT_SUM_W-1:0] sum;
      ready_vec  = '0;
      search_vec = '0;
      next_found = 1'b0;
      next_idx   = cur_ff;
      ready_cnt  = '0;
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         ready_vec[i]  = (slot_state_ff[i] == SLOT_READY);
         search_vec[i] = ready_vec[i] &&
                         !((req_data.func == FUNC_FINISH) && (SLOT_IDX_W'(i) == cur_ff));
      end
      for (int i = SLOT_COUNT; i >= 1; i--) begin
         sum = {1'b0, cur_ff} + SLOT_SUM_W'(i);
         if (sum >= SLOT_SUM_W'(SLOT_COUNT)) begin
            sum = sum - SLOT_SUM_W'(SLOT_COUNT);
         end
         if (search_vec[sum[SLOT_IDX_W-1:0]]) begin
            next_found = 1'b1;
            next_idx   = sum[SLOT_IDX_W-1:0];
         end
      end
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (search_vec[i] && (SLOT_IDX_W'(i) != next_idx)) begin
            ready_cnt = ready_cnt + SLOT_CNT_W'(1);
         end
      end
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (slot_state_ff[i] == SLOT_INVALID) begin
            free_found = 1'b1;
            free_idx   = SLOT_IDX_W'(i);
         end
      end
   end

   // operation decode
   always_comb begin
      pend_status_in  = STATUS_OK;
      pend_slot_in    = slot_field(cur_ff);
      pend_others_in  = 3'd0;
      pend_run_in     = '0;
      pend_use_mem_in = 1'b0;
      cur_in          = cur_ff;
      do_init         = 1'b0;
      do_claim        = 1'b0;
      do_done         = 1'b0;
      mem_we          = 1'b0;
      mem_re          = 1'b0;
      mem_addr        = next_idx;
      unique case (func_type'(req_data.func))
         FUNC_INIT: begin
            do_init      = accept;
            cur_in       = '0;
            pend_slot_in = 3'd0;
         end
         FUNC_CREATE: begin
            if (free_found) begin
               do_claim     = accept;
               mem_we       = accept;
               mem_addr     = free_idx;
               pend_slot_in = slot_field(free_idx);
               pend_run_in  = mem_wdata;
            end else begin
               pend_status_in = STATUS_NO_FREE;
               pend_slot_in   = 3'd0;
            end
         end
         FUNC_YIELD: begin
            if (next_found) begin
               mem_re          = accept;
               cur_in          = next_idx;
               pend_slot_in    = slot_field(next_idx);
               pend_others_in  = sat_count(ready_cnt);
               pend_use_mem_in = 1'b1;
            end else begin
               pend_status_in = STATUS_NONE_RDY;
            end
         end
         FUNC_FINISH: begin
            if (!ready_vec[cur_ff]) begin
               pend_status_in = STATUS_NOT_READY;
            end else begin
               do_done = accept;
               if (next_found) begin
                  mem_re          = accept;
                  cur_in          = next_idx;
                  pend_slot_in    = slot_field(next_idx);
                  pend_others_in  = sat_count(ready_cnt);
                  pend_use_mem_in = 1'b1;
               end else begin
                  pend_status_in = STATUS_ALL_DONE;
               end
            end
         end
         default: begin
            pend_status_in = STATUS_OK;
         end
      endcase
   end

   // slot table and current slot
   always_ff @(posedge clock) begin
      if (reset || do_init) begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            if (i == 0) begin
               slot_state_ff[i] <= SLOT_DONE;
            end else begin
               slot_state_ff[i] <= SLOT_INVALID;
            end
         end
         cur_ff <= '0;
      end else begin
         if (do_claim) begin
            slot_state_ff[free_idx] <= SLOT_READY;
         end
         if (do_done) begin
            slot_state_ff[cur_ff] <= SLOT_DONE;
         end
         if (accept) begin
            cur_ff <= cur_in;
         end
      end
   end

   // entry and argument memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rd_ff <= slot_mem[mem_addr];
      end
   end

   // pending result fields
   always_ff @(posedge clock) begin
      if (accept) begin
         pend_status_ff  <= pend_status_in;
         pend_slot_ff    <= pend_slot_in;
         pend_others_ff  <= pend_others_in;
         pend_run_ff     <= pend_run_in;
         pend_use_mem_ff <= pend_use_mem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff       <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (fsm_ff)
            ST_IDLE: begin
               if (rsp_valid_ff && rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
               end
               if (accept) begin
                  fsm_ff <= ST_READ;
               end
            end
            ST_READ: begin
               if (rsp_free) begin
                  rsp_valid_ff        <= 1'b1;
                  rsp_ff.status       <= pend_status_ff;
                  rsp_ff.slot         <= pend_slot_ff;
                  rsp_ff.others_ready <= pend_others_ff;
                  if (pend_use_mem_ff) begin
                     rsp_ff.run_entry <= mem_rd_ff.entry;
                     rsp_ff.run_arg_a <= mem_rd_ff.arg_a;
                     rsp_ff.run_arg_b <= mem_rd_ff.arg_b;
                  end else begin
                     rsp_ff.run_entry <= pend_run_ff.entry;
                     rsp_ff.run_arg_a <= pend_run_ff.arg_a;
                     rsp_ff.run_arg_b <= pend_run_ff.arg_b;
                  end
                  fsm_ff <= ST_IDLE;
               end
            end
            default: begin
               fsm_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule
